>>> rtl/core/swa_pkg.sv
// package for the scan window averager: constants, quality bits, register indexes
`timescale 1ns / 1ps
package swa_pkg;
    localparam int DEPTH_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int QUALITY_BITS_DEF = 8;
    localparam int NCHAN = 7;
    localparam int STAMP_BITS = 64;
    localparam int FLAG_BITS = 8;
    localparam int CNT_BITS = 7;
    localparam int ADDR_BITS = 4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FLAGGED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic [FLAG_BITS-1:0] Q_NONFINITE = 8'h01;
    localparam logic [FLAG_BITS-1:0] Q_TIMING = 8'h02;
    localparam logic [FLAG_BITS-1:0] Q_GAP = 8'h04;

    localparam logic [ADDR_BITS-1:0] REG_MIN_SCANS = 4'h0;
    localparam logic [ADDR_BITS-1:0] REG_MAX_GAP = 4'h8;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_ALIGN = 1'b1;
endpackage

>>> rtl/core/swa_div.sv
// sequential signed divider: truncating quotient of a sum by the scan count
`timescale 1ns / 1ps
module swa_div
    import swa_pkg::*;
#(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg;
    logic [DEN_BITS:0]   rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic                neg_reg;
    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   shifted;

    always_comb
    begin
        shifted = {rem_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
        trial = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_BITS-1];
            q_reg <= num[NUM_BITS-1] ? (~num + 1'b1) : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_BITS])
            begin
                rem_reg <= trial;
                q_reg <= {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg <= {q_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    // sign applied on the way out so the quotient is final while done is high
    assign quot = neg_reg ? (~q_reg + 1'b1) : q_reg;
endmodule

>>> rtl/core/scan_window_averager.sv
// top level of the scan window averager: ring memories, walk sequencer, apb registers
// push: result in the cycle after the accepted word; align: walk the filled entries of the ring
// memory, then divide the seven channel sums one after another in one shared serial divider
// (no division for an empty window), then the result; one word at a time
// reset clears write position and fill count, sets min scans to 1 and max gap to 0; ring memories are not cleared
`timescale 1ns / 1ps
module scan_window_averager
    import swa_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int QUALITY_BITS = QUALITY_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [STAMP_BITS-1:0]        stamp,
    input  logic [STAMP_BITS-1:0]        end_stamp,
    input  logic [FLAG_BITS-1:0]         flags_in,
    input  logic                         nonfinite,
    input  logic signed [VALUE_BITS-1:0] chan_kv,
    input  logic signed [VALUE_BITS-1:0] chan_current,
    input  logic signed [VALUE_BITS-1:0] chan_residual,
    input  logic signed [VALUE_BITS-1:0] chan_filament,
    input  logic signed [VALUE_BITS-1:0] chan_temp,
    input  logic signed [VALUE_BITS-1:0] chan_vacuum,
    input  logic signed [VALUE_BITS-1:0] chan_flux,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [FLAG_BITS-1:0]         quality,
    output logic [CNT_BITS-1:0]          sample_count,
    output logic [STAMP_BITS-1:0]        max_gap,
    output logic signed [VALUE_BITS-1:0] avg_kv,
    output logic signed [VALUE_BITS-1:0] avg_current,
    output logic signed [VALUE_BITS-1:0] avg_residual,
    output logic signed [VALUE_BITS-1:0] avg_filament,
    output logic signed [VALUE_BITS-1:0] avg_temp,
    output logic signed [VALUE_BITS-1:0] avg_vacuum,
    output logic signed [VALUE_BITS-1:0] avg_flux
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = VALUE_BITS + FW + 1;
    localparam int QB = (QUALITY_BITS < FLAG_BITS) ? QUALITY_BITS : FLAG_BITS;
    localparam logic [FLAG_BITS-1:0] QMASK = FLAG_BITS'((1 << QB) - 1);
    localparam int CHW = $clog2(NCHAN);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_LAST, S_DIV, S_DWAIT, S_OUT
    } state_t;

    typedef logic signed [VALUE_BITS-1:0] val_t;

    state_t state_reg;
    logic [AW-1:0] write_pos_reg;
    logic [FW-1:0] fill_count_reg;
    logic [CNT_BITS-1:0] min_scans_reg;
    logic [STAMP_BITS-1:0] max_gap_us_reg;

    // ring memories
    logic [STAMP_BITS-1:0] mem_stamp [DEPTH];
    logic [NCHAN*VALUE_BITS-1:0] mem_val [DEPTH];
    logic [FLAG_BITS-1:0] mem_flag [DEPTH];
    logic [STAMP_BITS-1:0] rd_stamp;
    logic [NCHAN*VALUE_BITS-1:0] rd_val;
    logic [FLAG_BITS-1:0] rd_flag;

    logic mem_we;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_addr_reg;
    logic [FW-1:0] walk_reg;
    logic rd_live_reg;

    logic [STAMP_BITS-1:0] start_reg, end_reg, prev_reg, gap_reg;
    logic have_prev_reg;
    logic [FLAG_BITS-1:0] q_reg;
    logic [FW-1:0] cnt_reg;
    logic signed [SW-1:0] sum_reg [NCHAN];
    val_t avg_reg [NCHAN];
    logic [CHW-1:0] ch_reg;
    logic [1:0] status_reg;

    logic push_ok;
    logic accept;
    logic in_win;
    logic [STAMP_BITS-1:0] gdiff;
    logic div_start, div_done;
    logic [SW-1:0] div_quot;
    logic [FLAG_BITS-1:0] q_fin;
    logic [FLAG_BITS-1:0] push_flags;

    assign pready = 1'b1;
    assign in_ready = (state_reg == S_IDLE) && !out_valid;
    assign accept = in_valid && in_ready;
    assign push_ok = accept && (req_type == REQ_PUSH) && (stamp != '0);
    assign mem_we = push_ok;
    assign push_flags = (flags_in | (nonfinite ? Q_NONFINITE : '0)) & QMASK;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_stamp[write_pos_reg] <= stamp;
            mem_flag[write_pos_reg] <= push_flags;
            mem_val[write_pos_reg] <= {chan_flux, chan_vacuum, chan_temp, chan_filament,
                                       chan_residual, chan_current, chan_kv};
        end
        rd_stamp <= mem_stamp[rd_addr];
        rd_flag <= mem_flag[rd_addr];
        rd_val <= mem_val[rd_addr];
    end

    // oldest entry on align, then step along the ring
    always_comb
    begin
        if (state_reg == S_IDLE)
            rd_addr = ((AW+1)'(fill_count_reg) <= {1'b0, write_pos_reg})
                      ? AW'({1'b0, write_pos_reg} - (AW+1)'(fill_count_reg))
                      : AW'({1'b0, write_pos_reg} + (AW+1)'(DEPTH)
                            - (AW+1)'(fill_count_reg));
        else if (rd_addr_reg == AW'(DEPTH - 1))
            rd_addr = '0;
        else
            rd_addr = rd_addr_reg + 1'b1;
    end

    assign in_win = (rd_stamp >= start_reg) && (rd_stamp <= end_reg);
    assign gdiff = rd_stamp - prev_reg;

    always_comb
    begin
        q_fin = q_reg;
        if (CNT_BITS'(cnt_reg) < min_scans_reg || (FW > CNT_BITS && cnt_reg > FW'(127)))
            q_fin = q_fin | ((CNT_BITS'(cnt_reg) < min_scans_reg && !(cnt_reg > FW'(127)))
                             ? Q_GAP : '0);
        if (FW'(min_scans_reg) > cnt_reg)
            q_fin = q_fin | Q_GAP;
        if (max_gap_us_reg != '0 && gap_reg > max_gap_us_reg)
            q_fin = q_fin | Q_GAP;
        q_fin = q_fin & QMASK;
    end

    assign div_start = (state_reg == S_DIV);

    swa_div #(.NUM_BITS(SW), .DEN_BITS(FW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(sum_reg[ch_reg]), .den(cnt_reg),
        .done(div_done), .quot(div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            write_pos_reg <= '0;
            fill_count_reg <= '0;
            out_valid <= 1'b0;
            min_scans_reg <= CNT_BITS'(1);
            max_gap_us_reg <= '0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr)
                    REG_MIN_SCANS:
                        min_scans_reg <= (pwdata[CNT_BITS-1:0] == '0) ? CNT_BITS'(1)
                                                                      : pwdata[CNT_BITS-1:0];
                    REG_MAX_GAP: max_gap_us_reg <= pwdata;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == REQ_PUSH)
                        begin
                            out_valid <= 1'b1;
                            if (push_ok)
                            begin
                                write_pos_reg <= (write_pos_reg == AW'(DEPTH - 1)) ? '0
                                                 : write_pos_reg + 1'b1;
                                if (fill_count_reg != FW'(DEPTH))
                                    fill_count_reg <= fill_count_reg + 1'b1;
                            end
                        end
                        else if (fill_count_reg == '0)
                            state_reg <= S_DIV;
                        else
                            state_reg <= (fill_count_reg == FW'(1)) ? S_LAST : S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (walk_reg == fill_count_reg - FW'(1))
                        state_reg <= S_LAST;
                end
                S_LAST: state_reg <= S_DIV;
                S_DIV: state_reg <= (cnt_reg == '0) ? S_OUT : S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                        state_reg <= (ch_reg == CHW'(NCHAN - 1)) ? S_OUT : S_DIV;
                end
                S_OUT:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
        if (accept)
        begin
            start_reg <= stamp;
            end_reg <= end_stamp;
            have_prev_reg <= 1'b0;
            prev_reg <= '0;
            gap_reg <= '0;
            cnt_reg <= '0;
            ch_reg <= '0;
            walk_reg <= FW'(1);
            rd_live_reg <= (req_type == REQ_ALIGN) && (fill_count_reg != '0);
            for (int k = 0; k < NCHAN; k++)
            begin
                sum_reg[k] <= '0;
                avg_reg[k] <= '0;
            end
            q_reg <= (flags_in | (nonfinite ? Q_NONFINITE : '0)
                      | ((stamp == '0 || end_stamp < stamp) ? Q_TIMING : '0)) & QMASK;
            if (req_type == REQ_PUSH)
                status_reg <= push_ok ? ST_OK : ST_REJECTED;
        end
        else
        begin
            if (state_reg == S_WALK)
                walk_reg <= walk_reg + 1'b1;
            rd_live_reg <= (state_reg == S_WALK);
            if (rd_live_reg && in_win)
            begin
                if (have_prev_reg && gdiff > gap_reg)
                    gap_reg <= gdiff;
                prev_reg <= rd_stamp;
                have_prev_reg <= 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
                q_reg <= (q_reg | rd_flag) & QMASK;
                for (int k = 0; k < NCHAN; k++)
                    sum_reg[k] <= sum_reg[k]
                        + SW'(signed'(rd_val[k*VALUE_BITS +: VALUE_BITS]));
            end
            if (state_reg == S_DWAIT && div_done)
            begin
                avg_reg[ch_reg] <= div_quot[VALUE_BITS-1:0];
                if (ch_reg != CHW'(NCHAN - 1))
                    ch_reg <= ch_reg + 1'b1;
            end
            if (state_reg == S_OUT)
                status_reg <= (q_fin == '0) ? ST_OK : ST_FLAGGED;
        end
    end

    logic align_res;
    always_ff @(posedge clk)
    begin
        if (accept)
            align_res <= (req_type == REQ_ALIGN);
    end

    assign status = status_reg;
    assign quality = align_res ? q_fin : '0;
    assign sample_count = align_res ? CNT_BITS'(cnt_reg) : '0;
    assign max_gap = align_res ? gap_reg : '0;
    assign avg_kv = avg_reg[0];
    assign avg_current = avg_reg[1];
    assign avg_residual = avg_reg[2];
    assign avg_filament = avg_reg[3];
    assign avg_temp = avg_reg[4];
    assign avg_vacuum = avg_reg[5];
    assign avg_flux = avg_reg[6];

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            REG_MIN_SCANS: prdata = 64'(min_scans_reg);
            REG_MAX_GAP: prdata = max_gap_us_reg;
            default: prdata = '0;
        endcase
    end

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FW'(DEPTH)) else $error("fill count overflow");
    a_min: assert property (@(posedge clk) disable iff (!rst_n)
        min_scans_reg != '0) else $error("min scans zero");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready) else $error("ready while busy");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fill_count_reg || state_reg == S_IDLE) else $error("count exceeds fill");
endmodule

>>> test/tb_scan_window_averager.sv
// testbench for the scan window averager: directed and random pushes and aligns checked word by word
`timescale 1ns / 1ps
module tb_scan_window_averager;
    import swa_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  quality;
        logic [6:0]  sample_count;
        logic [63:0] max_gap;
        logic [6:0][31:0] avg;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = 1'b0;
    logic [63:0] stamp = '0, end_stamp = '0;
    logic [7:0] flags_in = '0;
    logic nonfinite = 1'b0;
    logic signed [31:0] chan_kv = '0, chan_current = '0, chan_residual = '0,
        chan_filament = '0, chan_temp = '0, chan_vacuum = '0, chan_flux = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] quality;
    logic [6:0] sample_count;
    logic [63:0] max_gap;
    logic signed [31:0] avg_kv, avg_current, avg_residual, avg_filament, avg_temp,
        avg_vacuum, avg_flux;

    logic [63:0] scan_stamp [64];
    logic signed [31:0] scan_chan [64][7];
    logic [7:0] scan_flags [64];
    int unsigned wr_pos, fill;
    logic [6:0] min_scans_q;
    logic [63:0] max_gap_q;

    result_t pending_results [$];
    int unsigned errors;
    int unsigned stall_cycles;
    bit idle_off;
    logic [63:0] base_time;

    scan_window_averager u_top (.*);

    always #5 clk = ~clk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("error %s: got %h expected %h at %0t", what, got, exp, $time);
        errors++;
    endtask

    function automatic result_t predict_window(input logic rt, input logic [63:0] s,
        input logic [63:0] e, input logic [7:0] fl, input logic nf,
        input logic signed [31:0] ch [7]);
        result_t r;
        logic [7:0] q;
        longint sum [7];
        logic [63:0] prev, gmax, g;
        bit have_prev;
        int unsigned cnt, idx;
        r = '0;
        q = fl;
        if (rt == REQ_PUSH) begin
            if (s == 0) begin
                r.status = ST_REJECTED;
                return r;
            end
            if (nf) q |= Q_NONFINITE;
            scan_stamp[wr_pos] = s;
            scan_flags[wr_pos] = q;
            for (int k = 0; k < 7; k++) scan_chan[wr_pos][k] = ch[k];
            wr_pos = (wr_pos + 1) % 64;
            if (fill < 64) fill++;
            return r;
        end
        for (int k = 0; k < 7; k++) sum[k] = 0;
        prev = 0; gmax = 0; have_prev = 0; cnt = 0;
        if (s == 0 || e < s) q |= Q_TIMING;
        if (nf) q |= Q_NONFINITE;
        for (int i = 0; i < fill; i++) begin
            idx = (wr_pos + 64 - fill + i) % 64;
            if (scan_stamp[idx] < s || scan_stamp[idx] > e) continue;
            if (have_prev) begin
                g = scan_stamp[idx] - prev;
                if (g > gmax) gmax = g;
            end
            prev = scan_stamp[idx];
            have_prev = 1;
            cnt++;
            for (int k = 0; k < 7; k++) sum[k] += scan_chan[idx][k];
            q |= scan_flags[idx];
        end
        if (cnt < min_scans_q) q |= Q_GAP;
        if (max_gap_q != 0 && gmax > max_gap_q) q |= Q_GAP;
        r.status = (q == 0) ? ST_OK : ST_FLAGGED;
        r.quality = q;
        r.sample_count = cnt[6:0];
        r.max_gap = gmax;
        if (cnt != 0)
            for (int k = 0; k < 7; k++) r.avg[k] = 32'(sum[k] / longint'(cnt));
        return r;
    endfunction

    task automatic write_reg(input logic [ADDR_BITS-1:0] a, input logic [63:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == REG_MIN_SCANS) min_scans_q = (v[6:0] == 0) ? 7'd1 : v[6:0];
        else if (a == REG_MAX_GAP) max_gap_q = v;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic send_word(input logic rt, input logic [63:0] s, input logic [63:0] e,
        input logic [7:0] fl, input logic nf, input logic signed [31:0] ch [7]);
        while (!idle_off && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1; req_type <= rt; stamp <= s; end_stamp <= e;
        flags_in <= fl; nonfinite <= nf;
        chan_kv <= ch[0]; chan_current <= ch[1]; chan_residual <= ch[2];
        chan_filament <= ch[3]; chan_temp <= ch[4]; chan_vacuum <= ch[5]; chan_flux <= ch[6];
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_window(rt, s, e, fl, nf, ch));
    endtask

    function automatic void rand_chans(output logic signed [31:0] ch [7]);
        for (int k = 0; k < 7; k++)
            case ($urandom_range(5))
                0: ch[k] = 32'sh7fffffff;
                1: ch[k] = 32'sh80000000;
                default: ch[k] = $urandom;
            endcase
    endfunction

    task automatic push_scan(input logic [63:0] s);
        logic signed [31:0] ch [7];
        rand_chans(ch);
        send_word(REQ_PUSH, s, {$urandom, $urandom}, 8'($urandom), $urandom_range(9) == 0,
            ch);
    endtask

    task automatic align(input logic [63:0] s, input logic [63:0] e);
        logic signed [31:0] ch [7];
        rand_chans(ch);
        send_word(REQ_ALIGN, s, e, ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00,
            $urandom_range(9) == 0, ch);
    endtask

    task automatic test_directed();
        logic signed [31:0] ch [7];
        for (int k = 0; k < 7; k++) ch[k] = 32'sh7fffffff;
        send_word(REQ_PUSH, 64'd0, '1, 8'hff, 1'b1, ch);
        align(64'd1, '1);
        send_word(REQ_PUSH, 64'd100, '1, 8'h00, 1'b0, ch);
        for (int k = 0; k < 7; k++) ch[k] = 32'sh80000000;
        send_word(REQ_PUSH, 64'd200, 64'd0, 8'hf8, 1'b1, ch);
        send_word(REQ_PUSH, '1, 64'd0, 8'h00, 1'b0, ch);
        send_word(REQ_PUSH, 64'd150, 64'd0, 8'h00, 1'b0, ch);
        align(64'd100, 64'd200);
        align(64'd100, 64'd100);
        align(64'd0, '1);
        align(64'd300, 64'd100);
        align(64'd500, 64'd600);
        align(64'd1, '1);
        drain();
    endtask

    task automatic test_registers();
        write_reg(REG_MIN_SCANS, 64'd0);
        write_reg(REG_MAX_GAP, 64'd50);
        align(64'd100, 64'd200);
        align(64'd1, '1);
        drain();
        write_reg(REG_MIN_SCANS, 64'd64);
        write_reg(REG_MAX_GAP, '1);
        align(64'd1, '1);
        drain();
        write_reg(REG_MIN_SCANS, 64'hff);
        write_reg(REG_MAX_GAP, 64'd0);
        align(64'd1, '1);
        drain();
    endtask

    task automatic test_random(input int unsigned n_items);
        logic [63:0] lo, hi;
        int unsigned sent;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 400 == 0) begin
                drain();
                write_reg(REG_MIN_SCANS, 64'($urandom_range(127)));
                write_reg(REG_MAX_GAP, ($urandom_range(3) == 0) ? 64'd0 :
                    64'($urandom_range(60)));
            end
            idle_off = (sent % 400) >= 300;
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(19) == 0) push_scan(($urandom_range(1)) ? 64'd0 :
                    {$urandom, $urandom});
                else begin
                    base_time += 64'($urandom_range(40));
                    if ($urandom_range(29) == 0) base_time -= 200;
                    push_scan(base_time);
                end
            end else begin
                lo = base_time - 64'($urandom_range(1500));
                hi = lo + 64'($urandom_range(1500));
                if ($urandom_range(9) == 0) hi = lo - 1;
                if ($urandom_range(19) == 0) lo = 0;
                align(lo, hi);
            end
            sent++;
        end
        idle_off = 0;
    endtask

    initial begin
        errors = 0; wr_pos = 0; fill = 0; min_scans_q = 7'd1; max_gap_q = 0;
        idle_off = 0; base_time = 64'd5000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers();
        test_random(1650);
        drain();
        if (errors == 0)
            $display("scan_window_averager: match");
        else
            $display("scan_window_averager: mismatch");
        $finish;
    end

    always @(posedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (idle_off) out_ready <= 1'b1;
        else out_ready <= $urandom_range(99) >= 27;
    end

    always @(posedge clk) begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected word", {62'd0, status}, 64'd0);
            end else begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status) report("status", status, exp_r.status);
                if (quality !== exp_r.quality) report("quality", quality, exp_r.quality);
                if (sample_count !== exp_r.sample_count)
                    report("sample_count", sample_count, exp_r.sample_count);
                if (max_gap !== exp_r.max_gap) report("max_gap", max_gap, exp_r.max_gap);
                if (avg_kv !== exp_r.avg[0]) report("avg_kv", avg_kv, exp_r.avg[0]);
                if (avg_current !== exp_r.avg[1])
                    report("avg_current", avg_current, exp_r.avg[1]);
                if (avg_residual !== exp_r.avg[2])
                    report("avg_residual", avg_residual, exp_r.avg[2]);
                if (avg_filament !== exp_r.avg[3])
                    report("avg_filament", avg_filament, exp_r.avg[3]);
                if (avg_temp !== exp_r.avg[4]) report("avg_temp", avg_temp, exp_r.avg[4]);
                if (avg_vacuum !== exp_r.avg[5])
                    report("avg_vacuum", avg_vacuum, exp_r.avg[5]);
                if (avg_flux !== exp_r.avg[6]) report("avg_flux", avg_flux, exp_r.avg[6]);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000) begin
            $display("scan_window_averager: mismatch");
            $finish;
        end
    end
endmodule

>>> files.f
rtl/core/swa_pkg.sv
rtl/core/swa_div.sv
rtl/core/scan_window_averager.sv
test/tb_scan_window_averager.sv
